@@ sv/gpww_pkg.sv @@
// Shared types and constants for the greedy word-wrap block.
// No dependencies; imported by the CSR, datapath, controller and top level.
package gpww_pkg;

   // Text bytes with a meaning of their own
   localparam logic [7:0] NlByte = 8'd10;
   localparam logic [7:0] SpByte = 8'd32;

   // Register map
   localparam int         CsrAddrW         = 3;
   localparam int         CsrDataW         = 32;
   localparam logic [2:0] CsrLineWidthAddr = 3'd0;
   localparam logic [7:0] LineWidthReset   = 8'd72;

   // Source of the byte loaded into the output register
   typedef enum logic [1:0] {
      SEL_SEP  = 2'd0,
      SEL_WORD = 2'd1,
      SEL_NL   = 2'd2
   } gpww_sel_type;

   // Controller states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PLAN = 7'b0000010,
      ST_SEP  = 7'b0000100,
      ST_WORD = 7'b0001000,
      ST_BRK1 = 7'b0010000,
      ST_BRK2 = 7'b0100000,
      ST_FIN  = 7'b1000000
   } gpww_state_type;

   // Controller to datapath
   typedef struct packed {
      logic         accept;
      logic         load;
      gpww_sel_type sel;
      logic         last;
   } gpww_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;
      logic place;
      logic sep_none;
      logic brk;
      logic fin;
      logic word_last;
      logic idx_in_range;
      logic line_zero;
      logic word_empty;
      logic break_flag;
   } gpww_status_type;

endpackage

@@ sv/gpww_channels.sv @@
// Valid/ready channel interfaces for text input and reflowed output.
// Depends on nothing; used by the top level.
interface gpww_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, output ch, output end_of_text, input ready);
   modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface gpww_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;
   logic       word_truncated;

   modport source (output valid, output out_char, output last_of_run,
                   output word_truncated, input ready);
   modport sink   (input valid, input out_char, input last_of_run,
                   input word_truncated, output ready);
endinterface

@@ sv/gpww_csr.sv @@
// APB-style configuration register file: holds the line width.
// Depends on gpww_pkg.
module gpww_csr
   import gpww_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready,
   output logic [7:0]          line_width
);

   logic [7:0] line_width_ff;
   logic [7:0] line_width_in;
   logic       wr_hit;

   // Decode a completed write beat
   assign wr_hit = psel && penable && pwrite && (paddr == CsrLineWidthAddr);

   always_comb begin
      line_width_in = line_width_ff;
      if (wr_hit) begin
         line_width_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LineWidthReset;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   // Read back; unmapped addresses read zero
   assign prdata     = (paddr == CsrLineWidthAddr) ?
                       {{(CsrDataW-8){1'b0}}, line_width_ff} : '0;
   assign pready     = 1'b1;
   assign line_width = line_width_ff;

endmodule

@@ sv/gpww_datapath.sv @@
// Datapath: word buffer memory, line and paragraph state, per-item plan
// and the output register. Depends on gpww_pkg; driven by gpww_ctrl.
module gpww_datapath
   import gpww_pkg::*;
#(
   parameter int MaxWord = 60
) (
   input  logic            clock,
   input  logic            reset,
   input  gpww_cmd_type    cmd,
   output gpww_status_type status,
   input  logic [7:0]      req_ch,
   input  logic            req_end_of_text,
   input  logic [7:0]      line_width,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_of_run,
   output logic            rsp_word_truncated
);

   localparam int            LenW   = $clog2(MaxWord + 1);
   localparam int            IdxW   = (MaxWord > 1) ? $clog2(MaxWord) : 1;
   localparam logic [LenW-1:0] MaxLen = LenW'(MaxWord);

   // Text state
   logic [LenW-1:0] wl_ff, wl_in;
   logic            ovf_ff, ovf_in;
   logic [7:0]      line_ff, line_in;
   logic            pend_ff, pend_in;
   logic            brkd_ff, brkd_in;

   // Plan of the item in flight
   logic            place_ff, brk_ff, fin_ff, sep_none_ff, sep_nl_ff, trunc_ff;
   logic [LenW-1:0] emit_len_ff;

   // Word replay
   logic [7:0]      mem [MaxWord];
   logic [LenW-1:0] idx_ff, idx_in;
   logic [IdxW-1:0] rd_addr;
   logic [7:0]      rd_data_ff;

   // Output register
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_char_ff;
   logic            out_last_ff, out_trunc_ff;
   logic            slot_free;

   // Classification and placement decision for the incoming byte
   logic            is_nl, is_sp, is_word, full, store;
   logic [LenW-1:0] wl_new;
   logic            ovf_new, place_now, brk_now, fin_now, sep_none_now, fits;
   logic [8:0]      line_sum;
   logic [7:0]      line_place;

   always_comb begin
      is_nl        = (req_ch == NlByte);
      is_sp        = (req_ch == SpByte);
      is_word      = !is_nl && !is_sp;
      full         = (wl_ff == MaxLen);
      store        = is_word && !full;
      wl_new       = store ? wl_ff + LenW'(1) : wl_ff;
      ovf_new      = ovf_ff || (is_word && full);
      place_now    = is_word ? req_end_of_text : (wl_ff != '0);
      brk_now      = is_nl && pend_ff && (place_now || !brkd_ff);
      fin_now      = req_end_of_text && !brk_now && (place_now || !brkd_ff);
      line_sum     = {1'b0, line_ff} + 9'(wl_new) + 9'd1;
      fits         = (line_sum <= {1'b0, line_width});
      sep_none_now = (line_ff == 8'd0);
      if (!sep_none_now && fits) begin
         line_place = line_sum[7:0];
      end else begin
         line_place = 8'(wl_new);
      end
   end

   // Next text state on an accepted beat
   always_comb begin
      wl_in   = wl_ff;
      ovf_in  = ovf_ff;
      line_in = line_ff;
      pend_in = pend_ff;
      brkd_in = brkd_ff;
      if (cmd.accept) begin
         if (req_end_of_text) begin
            wl_in   = '0;
            ovf_in  = 1'b0;
            line_in = 8'd0;
            pend_in = 1'b0;
            brkd_in = 1'b1;
         end else begin
            wl_in   = place_now ? '0 : wl_new;
            ovf_in  = place_now ? 1'b0 : ovf_new;
            pend_in = is_nl && !pend_ff;
            if (brk_now) begin
               line_in = 8'd0;
               brkd_in = 1'b1;
            end else if (place_now) begin
               line_in = line_place;
               brkd_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff   <= '0;
         ovf_ff  <= 1'b0;
         line_ff <= 8'd0;
         pend_ff <= 1'b0;
         brkd_ff <= 1'b1;
      end else begin
         wl_ff   <= wl_in;
         ovf_ff  <= ovf_in;
         line_ff <= line_in;
         pend_ff <= pend_in;
         brkd_ff <= brkd_in;
      end
   end

   // Capture the plan for the controller
   always_ff @(posedge clock) begin
      if (reset) begin
         place_ff <= 1'b0;
         brk_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else if (cmd.accept) begin
         place_ff <= place_now;
         brk_ff   <= brk_now;
         fin_ff   <= fin_now;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sep_none_ff <= sep_none_now;
         sep_nl_ff   <= !fits;
         emit_len_ff <= wl_new;
         trunc_ff    <= ovf_new;
      end
   end

   // Buffer word bytes
   always_ff @(posedge clock) begin
      if (cmd.accept && store) begin
         mem[wl_ff[IdxW-1:0]] <= req_ch;
      end
   end

   // Replay index; read data always tracks the current index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.load && (cmd.sel == SEL_WORD)) begin
         idx_in = idx_ff + LenW'(1);
      end
      rd_addr = (idx_in < MaxLen) ? idx_in[IdxW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // Output register: load when the slot is empty or being drained
   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_last_ff <= cmd.last;
         case (cmd.sel)
            SEL_SEP: begin
               out_char_ff  <= sep_nl_ff ? NlByte : SpByte;
               out_trunc_ff <= trunc_ff;
            end
            SEL_WORD: begin
               out_char_ff  <= rd_data_ff;
               out_trunc_ff <= trunc_ff;
            end
            default: begin
               out_char_ff  <= NlByte;
               out_trunc_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_char       = out_char_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_word_truncated = out_trunc_ff;

   // Status back to the controller
   always_comb begin
      status.slot_free    = slot_free;
      status.place        = place_ff;
      status.sep_none     = sep_none_ff;
      status.brk          = brk_ff;
      status.fin          = fin_ff;
      status.word_last    = (idx_ff == (emit_len_ff - LenW'(1)));
      status.idx_in_range = (idx_ff < emit_len_ff);
      status.line_zero    = (line_ff == 8'd0);
      status.word_empty   = (wl_ff == '0);
      status.break_flag   = brkd_ff;
   end

endmodule

@@ sv/gpww_ctrl.sv @@
// Controller: sequences one item through plan, separator, word replay,
// paragraph break and final newline. Depends on gpww_pkg.
module gpww_ctrl
   import gpww_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  gpww_status_type status,
   output gpww_cmd_type    cmd
);

   gpww_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.load   = 1'b0;
      cmd.sel    = SEL_NL;
      cmd.last   = 1'b0;
      unique case (state_ff)
         // Take one byte
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PLAN;
            end
         end
         // Pick the first output step
         ST_PLAN: begin
            if (status.place) begin
               state_in = status.sep_none ? ST_WORD : ST_SEP;
            end else if (status.brk) begin
               state_in = ST_BRK1;
            end else if (status.fin) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         // Leading space or newline
         ST_SEP: begin
            if (status.slot_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SEL_SEP;
               state_in = ST_WORD;
            end
         end
         // Replay buffered word bytes
         ST_WORD: begin
            if (status.slot_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SEL_WORD;
               cmd.last = status.word_last && !status.brk && !status.fin;
               if (status.word_last) begin
                  if (status.brk) begin
                     state_in = ST_BRK1;
                  end else if (status.fin) begin
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         // Blank-line break, two newlines
         ST_BRK1: begin
            if (status.slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_BRK2;
            end
         end
         ST_BRK2: begin
            if (status.slot_free) begin
               cmd.load = 1'b1;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // Final newline at end of text
         ST_FIN: begin
            if (status.slot_free) begin
               cmd.load = 1'b1;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

@@ sv/greedy_paragraph_word_wrap_top.sv @@
// Greedy paragraph word wrap, top level. An input byte causes k result
// beats (0 to 63): it is accepted, then planned, then its beats leave one per
// cycle from the single output register while the sink keeps up. The first
// beat is loaded in the state after the plan state and is valid once registered.
// Synchronous reset restores line_width 72 and an empty
// paragraph; the word buffer is not cleared and needs no clearing pass.
module greedy_paragraph_word_wrap_top
   import gpww_pkg::*;
#(
   parameter int MAX_WORD = 60
) (
   input  logic                clock,
   input  logic                reset,
   gpww_req_if.sink            req,
   gpww_rsp_if.source          rsp,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready
);

   gpww_cmd_type    cmd;
   gpww_status_type status;
   logic [7:0]      line_width;
   logic            req_ready;

   // Configuration register
   gpww_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .line_width (line_width)
   );

   // Sequencer
   gpww_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req.ready = req_ready;

   // Buffer, line state and output register
   gpww_datapath #(
      .MaxWord (MAX_WORD)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_ch             (req.ch),
      .req_end_of_text    (req.end_of_text),
      .line_width         (line_width),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_out_char       (rsp.out_char),
      .rsp_last_of_run    (rsp.last_of_run),
      .rsp_word_truncated (rsp.word_truncated)
   );

   // End of text leaves a fresh paragraph behind
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req_ready && req.end_of_text) |=>
      (status.line_zero && status.word_empty && status.break_flag))
      else $error("text state not cleared after end of text");

   // Never overwrite a beat that has not been taken
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.slot_free)
      else $error("output register loaded while occupied");

   // Replay stays within the buffered word
   a_word_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && (cmd.sel == SEL_WORD)) |-> status.idx_in_range)
      else $error("word replay past buffered length");

endmodule
